FILE: src/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants for the two-port pad serial reader.
// ----------------------------------------------------------------------------
package spr_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_LATCH_TICKS  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_TICKS    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_TICKS    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAD_IS_SNES  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOUSE_ENABLE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_COMBO  = 3'd5;

   localparam logic [1:0] DEV_NONE  = 2'd0;
   localparam logic [1:0] DEV_PAD   = 2'd1;
   localparam logic [1:0] DEV_MOUSE = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_LATCH    = 3'd1,
      PH_GAP_PRE  = 3'd2,
      PH_LOW      = 3'd3,
      PH_GAP_POST = 3'd4
   } spr_phase_type;

   typedef struct packed {
      logic start_req;
      logic data1_level;
      logic data2_level;
   } spr_req_type;

   typedef struct packed {
      logic        latch_out;
      logic        clock_out;
      logic        busy_res;
      logic        done_res;
      logic [15:0] p1_word;
      logic [15:0] p2_word;
      logic [15:0] p1_extended;
      logic [15:0] p2_extended;
      logic [1:0]  connected;
      logic [1:0]  p1_device;
      logic [1:0]  p2_device;
      logic        reset_request;
   } spr_rsp_type;

   typedef struct packed {
      logic [7:0]  latch_ticks;
      logic [7:0]  gap_ticks;
      logic [7:0]  low_ticks;
      logic        pad_is_snes;
      logic        mouse_enable;
      logic [15:0] reset_combo;
   } spr_cfg_type;

   // per-transaction commands from the sequencer to both port lanes
   typedef struct packed {
      logic clear;
      logic shift_low;
      logic shift_high;
      logic capture_low;
      logic capture_high;
      logic keep_byte;
   } spr_lane_ctl_type;

   // pin levels and completion flags for the current tick
   typedef struct packed {
      logic latch;
      logic clk;
      logic busy;
      logic done;
   } spr_status_type;

   function automatic logic [1:0] spr_classify(input logic present, input logic [15:0] word);
      logic [1:0] dev;
      if (!present) begin
         dev = DEV_NONE;
      end else if (word[15]) begin
         dev = DEV_MOUSE;
      end else begin
         dev = DEV_PAD;
      end
      return dev;
   endfunction

   function automatic logic spr_count_done(input logic [7:0] count_inc, input logic [7:0] width);
      return (count_inc >= width) || (count_inc == 8'd0);
   endfunction

endpackage

FILE: src/spr_lane.sv
// ----------------------------------------------------------------------------
// spr_lane
// One controller port: presence flag, button and extended shift registers,
// held words.
// ----------------------------------------------------------------------------
module spr_lane
   import spr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  spr_lane_ctl_type ctl,
   input  logic             data_level,
   output logic             signature,
   output logic             present_in,
   output logic [15:0]      word_in,
   output logic [15:0]      ext_in
);

   logic        present_ff;
   logic [15:0] shift_low_ff, shift_low_in;
   logic [15:0] shift_high_ff, shift_high_in;
   logic [15:0] word_ff, ext_ff;
   logic [15:0] masked;

   assign masked    = ctl.keep_byte ? {8'h00, shift_low_ff[7:0]} : shift_low_ff;
   assign signature = masked[15];

   always_comb begin
      present_in    = present_ff;
      shift_low_in  = shift_low_ff;
      shift_high_in = shift_high_ff;
      if (ctl.clear) begin
         present_in    = ~data_level;
         shift_low_in  = '0;
         shift_high_in = '0;
      end
      if (ctl.shift_low) begin
         shift_low_in = {~data_level, shift_low_ff[15:1]};
      end
      if (ctl.shift_high) begin
         shift_high_in = {shift_high_ff[14:0], ~data_level};
      end
      word_in = ctl.capture_low  ? masked        : word_ff;
      ext_in  = ctl.capture_high ? shift_high_ff : ext_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff    <= 1'b0;
         shift_low_ff  <= '0;
         shift_high_ff <= '0;
         word_ff       <= '0;
         ext_ff        <= '0;
      end else begin
         present_ff    <= present_in;
         shift_low_ff  <= shift_low_in;
         shift_high_ff <= shift_high_in;
         word_ff       <= word_in;
         ext_ff        <= ext_in;
      end
   end

endmodule

FILE: src/spr_timing.sv
// ----------------------------------------------------------------------------
// spr_timing
// Bus sequencer: latch pulse, clock pulse train, bit count and the
// extended mouse pass. Advances one tick per accepted transaction.
// ----------------------------------------------------------------------------
module spr_timing
   import spr_pkg::*;
#(
   parameter int unsigned BITS_PER_READ = 16
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             start_req,
   input  spr_cfg_type      cfg,
   input  logic             sig_one,
   input  logic             sig_two,
   output spr_lane_ctl_type lane_ctl,
   output spr_status_type   status
);

   localparam int unsigned BC_W = $clog2(BITS_PER_READ);
   localparam logic [BC_W-1:0] LAST_BIT = BC_W'(BITS_PER_READ - 1);

   spr_phase_type   phase_ff, phase_in, phase_cur;
   logic [7:0]      tick_ff, tick_in, tick_cur, tick_inc;
   logic [BC_W-1:0] bit_ff, bit_in, bit_cur;
   logic            ext_ff, ext_in, ext_cur;
   logic            starting;
   spr_lane_ctl_type ctl;

   assign starting  = (phase_ff == PH_IDLE) && start_req;
   assign phase_cur = starting ? PH_LATCH : phase_ff;
   assign tick_cur  = starting ? 8'd0 : tick_ff;
   assign bit_cur   = starting ? '0 : bit_ff;
   assign ext_cur   = starting ? 1'b0 : ext_ff;
   assign tick_inc  = tick_cur + 8'd1;

   always_comb begin
      phase_in         = phase_cur;
      tick_in          = tick_cur;
      bit_in           = bit_cur;
      ext_in           = ext_cur;
      ctl              = '0;
      ctl.clear        = starting;
      ctl.keep_byte    = ~cfg.pad_is_snes;
      status.latch     = 1'b0;
      status.clk       = 1'b1;
      status.busy      = (phase_cur != PH_IDLE);
      status.done      = 1'b0;
      unique case (phase_cur)
         PH_IDLE: begin
         end
         PH_LATCH: begin
            status.latch = 1'b1;
            tick_in      = tick_inc;
            if (spr_count_done(tick_inc, cfg.latch_ticks)) begin
               phase_in = PH_GAP_PRE;
               tick_in  = 8'd0;
            end
         end
         PH_GAP_PRE: begin
            tick_in = tick_inc;
            if (spr_count_done(tick_inc, cfg.gap_ticks)) begin
               phase_in = PH_LOW;
               tick_in  = 8'd0;
            end
         end
         PH_LOW: begin
            status.clk = 1'b0;
            if (tick_cur == 8'd0) begin
               ctl.shift_low  = ~ext_cur;
               ctl.shift_high = ext_cur;
            end
            tick_in = tick_inc;
            if (spr_count_done(tick_inc, cfg.low_ticks)) begin
               phase_in = PH_GAP_POST;
               tick_in  = 8'd0;
            end
         end
         default: begin
            tick_in = tick_inc;
            if (spr_count_done(tick_inc, cfg.gap_ticks)) begin
               tick_in = 8'd0;
               if (bit_cur != LAST_BIT) begin
                  bit_in   = bit_cur + 1'b1;
                  phase_in = PH_GAP_PRE;
               end else begin
                  bit_in = '0;
                  if (!ext_cur) begin
                     ctl.capture_low = 1'b1;
                     if (cfg.mouse_enable && (sig_one || sig_two)) begin
                        ext_in   = 1'b1;
                        phase_in = PH_GAP_PRE;
                     end else begin
                        phase_in    = PH_IDLE;
                        status.done = 1'b1;
                     end
                  end else begin
                     ctl.capture_high = 1'b1;
                     ext_in           = 1'b0;
                     phase_in         = PH_IDLE;
                     status.done      = 1'b1;
                  end
               end
            end
         end
      endcase
   end

   always_comb begin
      lane_ctl              = ctl;
      lane_ctl.clear        = ctl.clear & accept;
      lane_ctl.shift_low    = ctl.shift_low & accept;
      lane_ctl.shift_high   = ctl.shift_high & accept;
      lane_ctl.capture_low  = ctl.capture_low & accept;
      lane_ctl.capture_high = ctl.capture_high & accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= 8'd0;
         bit_ff   <= '0;
         ext_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         ext_ff   <= ext_in;
      end
   end

endmodule

FILE: src/spr_merge.sv
// ----------------------------------------------------------------------------
// spr_merge
// Combines both lanes into one result: device classes, reset-combo match,
// and the result register with its valid flag.
// ----------------------------------------------------------------------------
module spr_merge
   import spr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  spr_status_type status,
   input  logic [15:0]    reset_combo,
   input  logic           present_one,
   input  logic           present_two,
   input  logic [15:0]    word_one,
   input  logic [15:0]    word_two,
   input  logic [15:0]    ext_one,
   input  logic [15:0]    ext_two,
   input  logic           rsp_stall,
   output logic           rsp_valid,
   output spr_rsp_type    rsp_payload
);

   logic        rsp_valid_ff, rsp_valid_in;
   spr_rsp_type rsp_ff, rsp_in;
   logic        combo_hit;

   assign combo_hit = (reset_combo != 16'd0)
                    && ((word_one == reset_combo) || (word_two == reset_combo));

   always_comb begin
      rsp_in.latch_out     = status.latch;
      rsp_in.clock_out     = status.clk;
      rsp_in.busy_res      = status.busy;
      rsp_in.done_res      = status.done;
      rsp_in.p1_word       = word_one;
      rsp_in.p2_word       = word_two;
      rsp_in.p1_extended   = ext_one;
      rsp_in.p2_extended   = ext_two;
      rsp_in.connected     = {present_two, present_one};
      rsp_in.p1_device     = spr_classify(present_one, word_one);
      rsp_in.p2_device     = spr_classify(present_two, word_two);
      rsp_in.reset_request = status.done & combo_hit;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: src/snes_pad_serial_reader.sv
// ----------------------------------------------------------------------------
// snes_pad_serial_reader
// Every request transaction is one bus tick. The block takes one tick per
// clock cycle and returns exactly one result per tick, in the next cycle from
// the result register; the next tick is taken while that result waits unless
// the result side stalls with the register full. A read of both ports takes
// latch_ticks + BITS_PER_READ * (2 * gap_ticks + low_ticks) ticks, twice the
// pulse train when an extended mouse pass follows; each port has its own
// shift lane, and a merge stage forms device classes and the reset request.
// ----------------------------------------------------------------------------
module snes_pad_serial_reader
   import spr_pkg::*;
#(
   parameter int unsigned BITS_PER_READ = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  spr_req_type            req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output spr_rsp_type            rsp_payload,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   spr_cfg_type      cfg_ff, cfg_in;
   spr_lane_ctl_type lane_ctl;
   spr_status_type   status;
   logic             accept;
   logic             sig_one, sig_two;
   logic             present_one, present_two;
   logic [15:0]      word_one, word_two, ext_one, ext_two;

   assign req_stall = rsp_valid & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_LATCH_TICKS:  cfg_in.latch_ticks  = csr_wdata[7:0];
            CSR_GAP_TICKS:    cfg_in.gap_ticks    = csr_wdata[7:0];
            CSR_LOW_TICKS:    cfg_in.low_ticks    = csr_wdata[7:0];
            CSR_PAD_IS_SNES:  cfg_in.pad_is_snes  = csr_wdata[0];
            CSR_MOUSE_ENABLE: cfg_in.mouse_enable = csr_wdata[0];
            CSR_RESET_COMBO:  cfg_in.reset_combo  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.latch_ticks  <= 8'd4;
         cfg_ff.gap_ticks    <= 8'd4;
         cfg_ff.low_ticks    <= 8'd1;
         cfg_ff.pad_is_snes  <= 1'b1;
         cfg_ff.mouse_enable <= 1'b0;
         cfg_ff.reset_combo  <= 16'd15;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   spr_timing #(
      .BITS_PER_READ (BITS_PER_READ)
   ) u_timing (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .start_req (req_payload.start_req),
      .cfg       (cfg_ff),
      .sig_one   (sig_one),
      .sig_two   (sig_two),
      .lane_ctl  (lane_ctl),
      .status    (status)
   );

   spr_lane u_lane_one (
      .clock      (clock),
      .reset      (reset),
      .ctl        (lane_ctl),
      .data_level (req_payload.data1_level),
      .signature  (sig_one),
      .present_in (present_one),
      .word_in    (word_one),
      .ext_in     (ext_one)
   );

   spr_lane u_lane_two (
      .clock      (clock),
      .reset      (reset),
      .ctl        (lane_ctl),
      .data_level (req_payload.data2_level),
      .signature  (sig_two),
      .present_in (present_two),
      .word_in    (word_two),
      .ext_in     (ext_two)
   );

   spr_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .status      (status),
      .reset_combo (cfg_ff.reset_combo),
      .present_one (present_one),
      .present_two (present_two),
      .word_one    (word_one),
      .word_two    (word_two),
      .ext_one     (ext_one),
      .ext_two     (ext_two),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: src/spr_checker.sv
// ----------------------------------------------------------------------------
// spr_checker
// Port-level checks on the result channel of the pad serial reader.
// ----------------------------------------------------------------------------
module spr_checker
   import spr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input spr_rsp_type rsp_payload
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("result transaction changed while stalled");

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.done_res) |-> rsp_payload.busy_res)
      else $error("done without busy");

   a_reset_req_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.reset_request) |-> rsp_payload.done_res)
      else $error("reset request outside completing tick");

   a_latch_clock_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.latch_out) |-> rsp_payload.clock_out)
      else $error("clock low during latch");

   a_device_present: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.p1_device != DEV_NONE)) |-> rsp_payload.connected[0])
      else $error("port 1 device without presence");

endmodule

bind snes_pad_serial_reader spr_checker u_spr_checker (.*);
